// ===== rtl/core/arle_pkg.sv =====
// Shared types and codes for the acknowledged link engine.
// No dependencies; read by the channel interfaces and the top level.
package arle_pkg;

   localparam int unsigned OpcodeWidth = 3;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LengthWidth = 7;
   localparam int unsigned RetryWidth  = 4;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDatWidth = 8;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_RADIO_IRQ = 3'd1,
      OP_HOST_SEND = 3'd2,
      OP_HOST_TAKE = 3'd3,
      OP_SET_MODE  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_STANDBY  = 2'd0,
      MODE_RECEIVE  = 2'd1,
      MODE_TRANSMIT = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ACK_IDLE    = 2'd0,
      ACK_WAITING = 2'd1,
      ACK_SENDING = 2'd2
   } ack_state_type;

   typedef enum logic [1:0] {
      RES_NONE = 2'd0,
      RES_OK   = 2'd1,
      RES_FAIL = 2'd2
   } ack_result_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_DISCARD = 3'd1,
      ACT_STORE   = 3'd2,
      ACT_ACK     = 3'd3,
      ACT_RETX    = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      CSR_USE_ACKS      = 3'd0,
      CSR_MAX_PAYLOAD   = 3'd1,
      CSR_ACK_FLAG_MASK = 3'd2,
      CSR_TIMEOUT_LIMIT = 3'd3,
      CSR_RETRY_LIMIT   = 3'd4,
      CSR_STUCK_LIMIT   = 3'd5
   } csr_index_type;

   localparam logic                   ResetUseAcks      = 1'b1;
   localparam logic [LengthWidth-1:0] ResetMaxPayload   = 7'd64;
   localparam logic [ByteWidth-1:0]   ResetAckFlagMask  = 8'h01;
   localparam logic [ByteWidth-1:0]   ResetTimeoutLimit = 8'd100;
   localparam logic [RetryWidth-1:0]  ResetRetryLimit   = 4'd3;
   localparam logic [ByteWidth-1:0]   ResetStuckLimit   = 8'd10;
   localparam logic [ByteWidth-1:0]   BroadcastAddr     = 8'h00;

endpackage

// ===== rtl/core/arle_req_if.sv =====
// Event channel into the link engine: valid/ready plus the event fields.
// Depends on arle_pkg for field widths.
interface arle_req_if;
   import arle_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OpcodeWidth-1:0] opcode;
   logic                   irq_line_high;
   logic [ByteWidth-1:0]   rx_length;
   logic [ByteWidth-1:0]   rx_receiver;
   logic [ByteWidth-1:0]   rx_sender;
   logic [ByteWidth-1:0]   rx_id;
   logic [ByteWidth-1:0]   rx_flags;
   logic [1:0]             new_mode;

   modport source (output valid, opcode, irq_line_high, rx_length, rx_receiver,
                   rx_sender, rx_id, rx_flags, new_mode, input ready);
   modport sink   (input valid, opcode, irq_line_high, rx_length, rx_receiver,
                   rx_sender, rx_id, rx_flags, new_mode, output ready);
endinterface

// ===== rtl/core/arle_rsp_if.sv =====
// Result channel out of the link engine: valid/ready plus action and status.
// Depends on arle_pkg for field widths.
interface arle_rsp_if;
   import arle_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [2:0]             action;
   logic [1:0]             radio_mode_out;
   logic [1:0]             ack_state_out;
   logic [1:0]             ack_result_out;
   logic                   new_packet_out;
   logic [ByteWidth-1:0]   reply_address;
   logic [ByteWidth-1:0]   reply_id;
   logic [LengthWidth-1:0] stored_length;
   logic [ByteWidth-1:0]   stored_receiver;
   logic [ByteWidth-1:0]   stored_flags;

   modport source (output valid, action, radio_mode_out, ack_state_out, ack_result_out,
                   new_packet_out, reply_address, reply_id, stored_length,
                   stored_receiver, stored_flags, input ready);
   modport sink   (input valid, action, radio_mode_out, ack_state_out, ack_result_out,
                   new_packet_out, reply_address, reply_id, stored_length,
                   stored_receiver, stored_flags, output ready);
endinterface

// ===== rtl/core/ack_retransmit_link_engine.sv =====
// Stop-and-wait link engine with duplicate filter for a packet radio.
// Depends on arle_pkg, arle_req_if and arle_rsp_if.
//
// Every event transaction on req_ch (tick, radio interrupt, host send, host
// pickup, host mode set) yields exactly one result transaction on rsp_ch,
// in order: the action for the radio front end (none, discard FIFO, store
// payload, send ack, retransmit) and the link status after the event. An
// event is captured in an input register and then applied to the link state
// in a single pass of logic whose outcome lands in the result register; a new
// event is taken every cycle as long as the result side keeps up, and a
// stalled result stalls the input register only when both are full.
// Configuration registers are written through
// csr_we/csr_index/csr_wdata and must only change while no event is in flight.
module ack_retransmit_link_engine (
   input  logic                             clock,
   input  logic                             reset,
   arle_req_if.sink                         req_ch,
   arle_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [arle_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [arle_pkg::CsrDatWidth-1:0] csr_wdata
);
   import arle_pkg::*;

   // Configuration registers
   logic                   use_acks_ff;
   logic [LengthWidth-1:0] max_payload_ff;
   logic [ByteWidth-1:0]   ack_flag_mask_ff;
   logic [ByteWidth-1:0]   timeout_limit_ff;
   logic [RetryWidth-1:0]  retry_limit_ff;
   logic [ByteWidth-1:0]   stuck_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_acks_ff      <= ResetUseAcks;
         max_payload_ff   <= ResetMaxPayload;
         ack_flag_mask_ff <= ResetAckFlagMask;
         timeout_limit_ff <= ResetTimeoutLimit;
         retry_limit_ff   <= ResetRetryLimit;
         stuck_limit_ff   <= ResetStuckLimit;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_USE_ACKS:      use_acks_ff      <= csr_wdata[0];
            CSR_MAX_PAYLOAD:   max_payload_ff   <= csr_wdata[LengthWidth-1:0];
            CSR_ACK_FLAG_MASK: ack_flag_mask_ff <= csr_wdata;
            CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_wdata;
            CSR_RETRY_LIMIT:   retry_limit_ff   <= csr_wdata[RetryWidth-1:0];
            CSR_STUCK_LIMIT:   stuck_limit_ff   <= csr_wdata;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // Input register stage
   logic                   in_valid_ff;
   logic [OpcodeWidth-1:0] in_opcode_ff;
   logic                   in_line_ff;
   logic [ByteWidth-1:0]   in_length_ff;
   logic [ByteWidth-1:0]   in_receiver_ff;
   logic [ByteWidth-1:0]   in_sender_ff;
   logic [ByteWidth-1:0]   in_id_ff;
   logic [ByteWidth-1:0]   in_flags_ff;
   logic [1:0]             in_mode_ff;

   logic rsp_valid_ff;
   logic advance;     // input-stage event applied to state this cycle
   logic req_take;

   // Advance the input stage whenever the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take  = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff   <= req_ch.opcode;
         in_line_ff     <= req_ch.irq_line_high;
         in_length_ff   <= req_ch.rx_length;
         in_receiver_ff <= req_ch.rx_receiver;
         in_sender_ff   <= req_ch.rx_sender;
         in_id_ff       <= req_ch.rx_id;
         in_flags_ff    <= req_ch.rx_flags;
         in_mode_ff     <= req_ch.new_mode;
      end
   end

   // Link state
   mode_type               radio_mode_ff,  radio_mode_in;
   ack_state_type          ack_state_ff,   ack_state_in;
   ack_result_type         ack_result_ff,  ack_result_in;
   logic [ByteWidth-1:0]   timeout_ff,     timeout_in;
   logic [RetryWidth-1:0]  retry_ff,       retry_in;
   logic [ByteWidth-1:0]   stuck_ff,       stuck_in;
   logic                   waiting_ff,     waiting_in;
   logic [ByteWidth-1:0]   last_id_ff,     last_id_in;
   logic [ByteWidth-1:0]   last_sender_ff, last_sender_in;
   logic [LengthWidth-1:0] last_length_ff, last_length_in;
   logic [ByteWidth-1:0]   last_rcv_ff,    last_rcv_in;
   logic [ByteWidth-1:0]   last_flags_ff,  last_flags_in;
   action_type             action_in;

   always_comb begin
      logic fire;
      logic store;

      radio_mode_in  = radio_mode_ff;
      ack_state_in   = ack_state_ff;
      ack_result_in  = ack_result_ff;
      timeout_in     = timeout_ff;
      retry_in       = retry_ff;
      stuck_in       = stuck_ff;
      waiting_in     = waiting_ff;
      last_id_in     = last_id_ff;
      last_sender_in = last_sender_ff;
      last_length_in = last_length_ff;
      last_rcv_in    = last_rcv_ff;
      last_flags_in  = last_flags_ff;
      action_in      = ACT_NONE;
      fire           = 1'b0;
      store          = 1'b0;

      case (opcode_type'(in_opcode_ff))
         OP_TICK: begin
            // Ack timeout while waiting: retransmit or give up.
            if (use_acks_ff && ack_state_in == ACK_WAITING) begin
               fire       = timeout_in > timeout_limit_ff;
               timeout_in = timeout_in + 8'd1;
               if (fire) begin
                  timeout_in = '0;
                  if (retry_in < retry_limit_ff) begin
                     retry_in      = retry_in + 4'd1;
                     radio_mode_in = MODE_TRANSMIT;
                     action_in     = ACT_RETX;
                  end else begin
                     ack_state_in  = ACK_IDLE;
                     ack_result_in = RES_FAIL;
                     retry_in      = '0;
                  end
               end
            end
            // Ack frame never reported done: drop back to standby.
            if (use_acks_ff && ack_state_in == ACK_SENDING) begin
               fire       = timeout_in > timeout_limit_ff;
               timeout_in = timeout_in + 8'd1;
               if (fire) begin
                  timeout_in    = '0;
                  ack_state_in  = ACK_IDLE;
                  radio_mode_in = MODE_STANDBY;
               end
            end
            // Interrupt line held high too long: force a receive restart.
            if (in_line_ff) begin
               fire     = stuck_in > stuck_limit_ff;
               stuck_in = stuck_in + 8'd1;
               if (fire) begin
                  stuck_in      = '0;
                  timeout_in    = '0;
                  ack_state_in  = ACK_IDLE;
                  radio_mode_in = MODE_RECEIVE;
               end
            end
         end
         OP_RADIO_IRQ: begin
            if (radio_mode_ff == MODE_RECEIVE) begin
               if (in_length_ff > {1'b0, max_payload_ff}) begin
                  action_in = ACT_DISCARD;
               end else if (!use_acks_ff) begin
                  store      = 1'b1;
                  waiting_in = 1'b1;
                  stuck_in   = '0;
                  action_in  = ACT_STORE;
               end else if ((in_flags_ff & ack_flag_mask_ff) != '0) begin
                  ack_state_in  = ACK_IDLE;
                  ack_result_in = RES_OK;
                  radio_mode_in = MODE_STANDBY;
                  stuck_in      = '0;
               end else begin
                  action_in = ACT_DISCARD;
                  // Store only a header that differs from the last one.
                  if (last_id_ff != in_id_ff || last_sender_ff != in_sender_ff) begin
                     store     = 1'b1;
                     action_in = ACT_STORE;
                     if (in_receiver_ff == BroadcastAddr) begin
                        waiting_in = 1'b1;
                        stuck_in   = '0;
                     end
                  end
                  if (in_receiver_ff != BroadcastAddr) begin
                     radio_mode_in = MODE_TRANSMIT;
                     ack_state_in  = ACK_SENDING;
                     stuck_in      = '0;
                     action_in     = ACT_ACK;
                  end
               end
            end else if (radio_mode_ff == MODE_TRANSMIT) begin
               // Transmit done.
               if (!use_acks_ff) begin
                  radio_mode_in = MODE_STANDBY;
               end else if (ack_state_ff == ACK_IDLE) begin
                  ack_state_in  = ACK_WAITING;
                  ack_result_in = RES_NONE;
                  timeout_in    = '0;
                  retry_in      = '0;
                  radio_mode_in = MODE_RECEIVE;
               end else if (ack_state_ff == ACK_SENDING) begin
                  ack_state_in  = ACK_IDLE;
                  radio_mode_in = MODE_STANDBY;
                  waiting_in    = 1'b1;
               end else begin
                  radio_mode_in = MODE_RECEIVE;
               end
            end
         end
         OP_HOST_SEND: radio_mode_in = MODE_TRANSMIT;
         OP_HOST_TAKE: waiting_in = 1'b0;
         OP_SET_MODE: begin
            case (mode_type'(in_mode_ff))
               MODE_STANDBY, MODE_RECEIVE, MODE_TRANSMIT:
                  radio_mode_in = mode_type'(in_mode_ff);
               default: ;  // hold mode on the unused code
            endcase
         end
         default: ;
      endcase

      if (store) begin
         last_length_in = in_length_ff[LengthWidth-1:0];
         last_rcv_in    = in_receiver_ff;
         last_sender_in = in_sender_ff;
         last_id_in     = in_id_ff;
         last_flags_in  = in_flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radio_mode_ff  <= MODE_STANDBY;
         ack_state_ff   <= ACK_IDLE;
         ack_result_ff  <= RES_NONE;
         timeout_ff     <= '0;
         retry_ff       <= '0;
         stuck_ff       <= '0;
         waiting_ff     <= 1'b0;
         last_id_ff     <= '0;
         last_sender_ff <= '0;
         last_length_ff <= '0;
         last_rcv_ff    <= '0;
         last_flags_ff  <= '0;
      end else if (advance) begin
         radio_mode_ff  <= radio_mode_in;
         ack_state_ff   <= ack_state_in;
         ack_result_ff  <= ack_result_in;
         timeout_ff     <= timeout_in;
         retry_ff       <= retry_in;
         stuck_ff       <= stuck_in;
         waiting_ff     <= waiting_in;
         last_id_ff     <= last_id_in;
         last_sender_ff <= last_sender_in;
         last_length_ff <= last_length_in;
         last_rcv_ff    <= last_rcv_in;
         last_flags_ff  <= last_flags_in;
      end
   end

   // Result register: hold until the sink takes the transaction.
   action_type     rsp_action_ff;
   mode_type       rsp_mode_ff;
   ack_state_type  rsp_ack_state_ff;
   ack_result_type rsp_ack_result_ff;
   logic           rsp_new_packet_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_action_ff     <= action_in;
         rsp_mode_ff       <= radio_mode_in;
         rsp_ack_state_ff  <= ack_state_in;
         rsp_ack_result_ff <= ack_result_in;
         rsp_new_packet_ff <= waiting_in;
      end
   end

   // Header fields in the result mirror the committed state registers.
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.action          = rsp_action_ff;
   assign rsp_ch.radio_mode_out  = rsp_mode_ff;
   assign rsp_ch.ack_state_out   = rsp_ack_state_ff;
   assign rsp_ch.ack_result_out  = rsp_ack_result_ff;
   assign rsp_ch.new_packet_out  = rsp_new_packet_ff;
   assign rsp_ch.reply_address   = last_sender_ff;
   assign rsp_ch.reply_id        = last_id_ff;
   assign rsp_ch.stored_length   = last_length_ff;
   assign rsp_ch.stored_receiver = last_rcv_ff;
   assign rsp_ch.stored_flags    = last_flags_ff;

endmodule
